@@ rtl/mdt_pkg.sv @@
// Shared types, codes and keyword tables of the markup tokenizer.
// Used by mdt_lexer, mdt_result_fifo and markup_dsl_tokenizer_core; no dependencies.
package mdt_pkg;

  localparam int MaxResults = 3;
  localparam int FifoDepth  = 8;

  localparam logic [3:0] KIND_COLON     = 4'd0;
  localparam logic [3:0] KIND_SEMICOLON = 4'd1;
  localparam logic [3:0] KIND_BLOCK     = 4'd2;
  localparam logic [3:0] KIND_TAG       = 4'd3;
  localparam logic [3:0] KIND_KEYWORD0  = 4'd4;
  localparam logic [3:0] KIND_EOF       = 4'd10;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNCLOSED   = 2'd1;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_SEMICOLON = 8'h3B;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DASH      = 8'h2D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;

  localparam int NumKeywords = 6;

  localparam logic [0:NumKeywords-1][0:7][7:0] KW_TEXT = {
    {"props", 24'h0}, {"content", 8'h0}, {"classes", 8'h0},
    {"ids", 40'h0}, {"dataset", 8'h0}, {"styles", 16'h0}
  };
  localparam logic [0:NumKeywords-1][3:0] KW_LEN = {4'd5, 4'd7, 4'd7, 4'd3, 4'd7, 4'd6};

  typedef struct packed {
    logic       value_valid;
    logic [7:0] value_char;
    logic       token_end;
    logic [3:0] token_kind;
    logic [1:0] error_code;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic [1:0]                   cnt;
    result_t [MaxResults-1:0]     item;
  } push_t;

  function automatic logic is_word_char(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
           (b >= 8'h30 && b <= 8'h39);
  endfunction

  function automatic logic [5:0] kw_mask_step(logic [5:0] m, logic [3:0] len,
                                              logic [7:0] b);
    logic [5:0] r;
    r = m;
    for (int k = 0; k < NumKeywords; k++) begin
      if (m[k] && (len >= KW_LEN[k] || KW_TEXT[k][len[2:0]] != b)) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [3:0] word_kind(logic [5:0] m, logic [3:0] len);
    logic [3:0] kind;
    kind = KIND_TAG;
    for (int k = NumKeywords - 1; k >= 0; k--) begin
      if (m[k] && len == KW_LEN[k]) begin
        kind = KIND_KEYWORD0 + 4'(k);
      end
    end
    return kind;
  endfunction

  function automatic result_t mk_result(logic vv, logic [7:0] ch, logic te,
                                        logic [3:0] kind, logic [1:0] err);
    result_t r;
    r.value_valid = vv;
    r.value_char  = ch;
    r.token_end   = te;
    r.token_kind  = kind;
    r.error_code  = err;
    r.last_result = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/mdt_lexer.sv @@
// Input register and per-byte tokenizer step: mode, word length and keyword mask.
// Produces up to three result beats per byte for mdt_result_fifo; uses mdt_pkg.
module mdt_lexer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     byte_value_i,
  input  logic           end_of_source_i,
  input  logic           space_ok_i,
  output mdt_pkg::push_t push_o
);
  import mdt_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_WORD, MODE_BLOCK, MODE_ESC, MODE_DASH, MODE_COMMENT, MODE_ERROR
  } mode_e;

  mode_e      mode_q, mode_d;
  logic [3:0] len_q, len_d;
  logic [5:0] mask_q, mask_d;
  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       eos_q;
  logic       go;

  result_t               idle_res;
  logic                  idle_put;
  mode_e                 idle_mode;
  logic [3:0]            idle_len;
  logic [5:0]            idle_mask;
  result_t [MaxResults-1:0] res;
  logic [1:0]            n;

  assign go         = vld_q && space_ok_i;
  assign in_ready_o = !vld_q || space_ok_i;

  always_comb begin
    vld_d = vld_q;
    if (in_valid_i && in_ready_o) begin
      vld_d = 1'b1;
    end else if (go) begin
      vld_d = 1'b0;
    end
  end

  always_comb begin
    idle_put  = 1'b0;
    idle_res  = mk_result(1'b0, 8'h00, 1'b0, KIND_COLON, ERR_NONE);
    idle_mode = MODE_IDLE;
    idle_len  = 4'd0;
    idle_mask = 6'h3F;
    priority if (byte_q == CH_COLON) begin
      idle_put = 1'b1;
      idle_res = mk_result(1'b1, byte_q, 1'b1, KIND_COLON, ERR_NONE);
    end else if (byte_q == CH_SEMICOLON) begin
      idle_put = 1'b1;
      idle_res = mk_result(1'b1, byte_q, 1'b1, KIND_SEMICOLON, ERR_NONE);
    end else if (byte_q == CH_LBRACE) begin
      idle_mode = MODE_BLOCK;
    end else if (byte_q == CH_DASH) begin
      idle_mode = MODE_DASH;
    end else if (is_word_char(byte_q)) begin
      idle_put  = 1'b1;
      idle_res  = mk_result(1'b1, byte_q, 1'b0, KIND_COLON, ERR_NONE);
      idle_mode = MODE_WORD;
      idle_len  = 4'd1;
      idle_mask = kw_mask_step(6'h3F, 4'd0, byte_q);
    end else if (byte_q == CH_SPACE || byte_q == CH_LF || byte_q == CH_CR ||
                 byte_q == CH_TAB) begin
      idle_mode = MODE_IDLE;
    end else begin
      idle_put  = 1'b1;
      idle_res  = mk_result(1'b0, 8'h00, 1'b0, KIND_COLON, ERR_UNEXPECTED);
      idle_mode = MODE_ERROR;
    end
  end

  always_comb begin
    mode_d = mode_q;
    len_d  = len_q;
    mask_d = mask_q;
    res    = '0;
    n      = 2'd0;
    unique case (mode_q)
      MODE_IDLE: begin
        mode_d = idle_mode;
        len_d  = idle_len;
        mask_d = idle_mask;
        if (idle_put) begin
          res[0] = idle_res;
          n      = 2'd1;
        end
      end
      MODE_WORD: begin
        if (is_word_char(byte_q)) begin
          mask_d = kw_mask_step(mask_q, len_q, byte_q);
          len_d  = (len_q == 4'hF) ? 4'hF : len_q + 4'd1;
          res[0] = mk_result(1'b1, byte_q, 1'b0, KIND_COLON, ERR_NONE);
          n      = 2'd1;
        end else begin
          res[0] = mk_result(1'b0, 8'h00, 1'b1, word_kind(mask_q, len_q), ERR_NONE);
          n      = 2'd1;
          mode_d = idle_mode;
          len_d  = idle_len;
          mask_d = idle_mask;
          if (idle_put) begin
            res[1] = idle_res;
            n      = 2'd2;
          end
        end
      end
      MODE_BLOCK: begin
        priority if (byte_q == CH_BACKSLASH) begin
          mode_d = MODE_ESC;
        end else if (byte_q == CH_RBRACE) begin
          res[0] = mk_result(1'b0, 8'h00, 1'b1, KIND_BLOCK, ERR_NONE);
          n      = 2'd1;
          mode_d = MODE_IDLE;
        end else begin
          res[0] = mk_result(1'b1, byte_q, 1'b0, KIND_COLON, ERR_NONE);
          n      = 2'd1;
        end
      end
      MODE_ESC: begin
        mode_d = MODE_BLOCK;
        priority if (byte_q == CH_LBRACE || byte_q == CH_RBRACE ||
                     byte_q == CH_BACKSLASH) begin
          res[0] = mk_result(1'b1, byte_q, 1'b0, KIND_COLON, ERR_NONE);
          n      = 2'd1;
        end else if (byte_q == CH_LOWER_N) begin
          res[0] = mk_result(1'b1, CH_LF, 1'b0, KIND_COLON, ERR_NONE);
          n      = 2'd1;
        end else if (byte_q == CH_LOWER_T) begin
          res[0] = mk_result(1'b1, CH_TAB, 1'b0, KIND_COLON, ERR_NONE);
          n      = 2'd1;
        end else begin
          res[0] = mk_result(1'b1, CH_BACKSLASH, 1'b0, KIND_COLON, ERR_NONE);
          res[1] = mk_result(1'b1, byte_q, 1'b0, KIND_COLON, ERR_NONE);
          n      = 2'd2;
        end
      end
      MODE_DASH: begin
        if (byte_q == CH_DASH) begin
          mode_d = MODE_COMMENT;
        end else begin
          res[0] = mk_result(1'b0, 8'h00, 1'b0, KIND_COLON, ERR_UNEXPECTED);
          n      = 2'd1;
          mode_d = MODE_ERROR;
        end
      end
      MODE_COMMENT: begin
        if (byte_q == CH_LF) begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_ERROR: begin
        mode_d = MODE_ERROR;
      end
      default: begin
        mode_d = MODE_ERROR;
      end
    endcase

    if (eos_q) begin
      unique case (mode_d)
        MODE_IDLE, MODE_COMMENT: begin
          res[n] = mk_result(1'b0, 8'h00, 1'b1, KIND_EOF, ERR_NONE);
          n      = n + 2'd1;
        end
        MODE_WORD: begin
          res[n] = mk_result(1'b0, 8'h00, 1'b1, word_kind(mask_d, len_d), ERR_NONE);
          n      = n + 2'd1;
          res[n] = mk_result(1'b0, 8'h00, 1'b1, KIND_EOF, ERR_NONE);
          n      = n + 2'd1;
        end
        MODE_ESC: begin
          res[n] = mk_result(1'b1, CH_BACKSLASH, 1'b0, KIND_COLON, ERR_NONE);
          n      = n + 2'd1;
          res[n] = mk_result(1'b0, 8'h00, 1'b0, KIND_COLON, ERR_UNCLOSED);
          n      = n + 2'd1;
        end
        MODE_BLOCK: begin
          res[n] = mk_result(1'b0, 8'h00, 1'b0, KIND_COLON, ERR_UNCLOSED);
          n      = n + 2'd1;
        end
        MODE_DASH: begin
          res[n] = mk_result(1'b0, 8'h00, 1'b0, KIND_COLON, ERR_UNEXPECTED);
          n      = n + 2'd1;
        end
        default: begin
          n = n;
        end
      endcase
      mode_d = MODE_IDLE;
      len_d  = 4'd0;
      mask_d = 6'h3F;
    end

    if (n != 2'd0) begin
      res[n - 2'd1].last_result = 1'b1;
    end
  end

  assign push_o.cnt  = go ? n : 2'd0;
  assign push_o.item = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      mode_q <= MODE_IDLE;
      len_q  <= 4'd0;
      mask_q <= 6'h3F;
    end else begin
      vld_q <= vld_d;
      if (go) begin
        mode_q <= mode_d;
        len_q  <= len_d;
        mask_q <= mask_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= byte_value_i;
      eos_q  <= end_of_source_i;
    end
  end

endmodule

@@ rtl/mdt_result_fifo.sv @@
// Result queue of the markup tokenizer: takes up to three beats per cycle,
// hands out one registered beat per cycle while out_ready_i is high. Uses mdt_pkg.
module mdt_result_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mdt_pkg::push_t   push_i,
  output logic             space_ok_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mdt_pkg::result_t out_data_o
);
  import mdt_pkg::*;

  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntW = $clog2(FifoDepth + 1);

  result_t           mem_q [FifoDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              pop;

  assign out_valid_o = count_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign space_ok_o  = count_q <= CntW'(FifoDepth - MaxResults);

  assign wr_ptr_d = wr_ptr_q + PtrW'(push_i.cnt);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign count_d  = count_q + CntW'(push_i.cnt) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxResults; i++) begin
      if (2'(i) < push_i.cnt) begin
        mem_q[wr_ptr_q + PtrW'(i)] <= push_i.item[i];
      end
    end
  end

endmodule

@@ rtl/markup_dsl_tokenizer_core.sv @@
// Top level of the markup tokenizer: byte input channel, result output channel.
// Instantiates mdt_lexer and mdt_result_fifo; uses mdt_pkg.
//
// The input channel takes one source byte per beat, with end_of_source_i set on
// the final byte of a text. The output channel gives one result per beat: a value
// character, a token end with its kind, or an error code. last_result_o marks the
// final result caused by a byte; a byte may cause zero to three results.
// A byte is registered on acceptance and is decoded from the input register once
// the queue has room, when its results are written into an eight-entry result
// queue that offers them on the output channel.
// Throughput is one byte per cycle while bytes cause at most one result each and
// out_ready_i is high; bytes with several results drain at one result per cycle.
// The input stalls when the queue has fewer than three free entries, so a stalled
// receiver backs up into the input channel once six results wait in the queue
// and a byte waits in the input register.
// Reset empties the queue and returns the tokenizer to idle with an empty word.
// After an error, bytes are dropped without results up to the end of the source.
module markup_dsl_tokenizer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_value_i,
  input  logic       end_of_source_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       value_valid_o,
  output logic [7:0] value_char_o,
  output logic       token_end_o,
  output logic [3:0] token_kind_o,
  output logic [1:0] error_code_o,
  output logic       last_result_o
);
  import mdt_pkg::*;

  push_t   push;
  logic    space_ok;
  result_t out_data;

  mdt_lexer u_lexer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .byte_value_i    (byte_value_i),
    .end_of_source_i (end_of_source_i),
    .space_ok_i      (space_ok),
    .push_o          (push)
  );

  mdt_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign value_valid_o = out_data.value_valid;
  assign value_char_o  = out_data.value_char;
  assign token_end_o   = out_data.token_end;
  assign token_kind_o  = out_data.token_kind;
  assign error_code_o  = out_data.error_code;
  assign last_result_o = out_data.last_result;

endmodule
